// File: design/cbpdc_pkg.sv
`timescale 1ns / 1ps
package cbpdc_pkg;

  localparam int MONEY_W     = 48;
  localparam int RATE_W      = 24;
  localparam int MAT_W       = 7;
  localparam int FREQ_W      = 4;
  localparam int DUR_W       = 24;
  localparam int CONV_W      = 32;
  localparam int YIELD_W     = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 48;
  localparam int WORD_W      = 64;
  localparam int WIDE_W      = 128;
  localparam int MAX_PERIODS_DEF = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_FACE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUPON   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MATURITY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ     = 3'd4;

  // Rounds a Q.32 product back to an integer word, saturating to 64 bits.
  function automatic logic [WORD_W-1:0] rnd32(input logic [WIDE_W-1:0] x);
    logic [WIDE_W-1:0] s;
    s = x + WIDE_W'(64'h8000_0000);
    if (s[127:96] != 32'd0) begin
      rnd32 = {WORD_W{1'b1}};
    end else begin
      rnd32 = s[95:32];
    end
  endfunction

endpackage

// File: design/cbpdc_mul.sv
`timescale 1ns / 1ps
module cbpdc_mul
  import cbpdc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [WORD_W-1:0] a_i,
  input  logic [WORD_W-1:0] b_i,
  output logic              done_o,
  output logic [WIDE_W-1:0] prod_o
);

  // One 32 by 32 partial product is accumulated per cycle.
  logic [1:0]        step_q, step_d;
  logic              run_q, run_d;
  logic              done_d;
  logic [WORD_W-1:0] a_q, a_d, b_q, b_d;
  logic [WIDE_W-1:0] acc_d;
  logic [31:0]       opa, opb;
  logic [63:0]       pp;
  logic [WIDE_W-1:0] pp_sh;

  always_comb begin
    opa = step_q[1] ? a_q[63:32] : a_q[31:0];
    opb = step_q[0] ? b_q[63:32] : b_q[31:0];
    pp  = 64'(opa) * 64'(opb);
    case (step_q)
      2'd0:    pp_sh = WIDE_W'(pp);
      2'd3:    pp_sh = WIDE_W'(pp) << 64;
      default: pp_sh = WIDE_W'(pp) << 32;
    endcase
  end

  always_comb begin
    step_d = step_q;
    run_d  = run_q;
    done_d = 1'b0;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = prod_o;
    if (start_i) begin
      a_d    = a_i;
      b_d    = b_i;
      acc_d  = '0;
      step_d = 2'd0;
      run_d  = 1'b1;
    end else if (run_q) begin
      acc_d  = prod_o + pp_sh;
      step_d = step_q + 2'd1;
      if (step_q == 2'd3) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 2'd0;
      run_q  <= 1'b0;
      done_o <= 1'b0;
    end else begin
      step_q <= step_d;
      run_q  <= run_d;
      done_o <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    prod_o <= acc_d;
  end

endmodule

// File: design/cbpdc_div.sv
`timescale 1ns / 1ps
module cbpdc_div
  import cbpdc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [WIDE_W-1:0] num_i,
  input  logic [WIDE_W-1:0] den_i,
  output logic              done_o,
  output logic [WORD_W-1:0] quo_o
);

  // Rounded restoring division, one quotient bit per cycle.
  logic              run_q, run_d, done_d;
  logic [6:0]        cnt_q, cnt_d;
  logic [WIDE_W-1:0] num_q, num_d, den_q, den_d, rem_q, rem_d, q_q, q_d;
  logic [WORD_W-1:0] quo_d;
  logic [WIDE_W:0]   rem2;
  logic              ge;

  always_comb begin
    rem2 = {rem_q, num_q[WIDE_W-1]};
    ge   = rem2 >= {1'b0, den_q};
  end

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    q_d    = q_q;
    quo_d  = quo_o;
    if (start_i) begin
      if (den_i == '0) begin
        quo_d  = '0;
        done_d = 1'b1;
      end else begin
        num_d = num_i + (den_i >> 1);
        den_d = den_i;
        rem_d = '0;
        q_d   = '0;
        cnt_d = 7'd0;
        run_d = 1'b1;
      end
    end else if (run_q) begin
      rem_d = ge ? WIDE_W'(rem2 - {1'b0, den_q}) : rem2[WIDE_W-1:0];
      q_d   = {q_q[WIDE_W-2:0], ge};
      num_d = num_q << 1;
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd127) begin
        run_d  = 1'b0;
        done_d = 1'b1;
        quo_d  = (q_d[127:64] != '0) ? {WORD_W{1'b1}} : q_d[63:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= 7'd0;
    end else begin
      run_q  <= run_d;
      done_o <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    q_q   <= q_d;
    quo_o <= quo_d;
  end

endmodule

// File: design/coupon_bond_price_duration_convexity_core.sv
`timescale 1ns / 1ps
// A market price is taken when start_i is high and busy_o is low; the bond terms come from
// the configuration registers. One shared multiplier (four partial products, one per cycle)
// and one shared divider (one quotient bit per cycle) do all the arithmetic under a sequencer.
// The work runs over n = maturity_years * payments_per_year periods, capped at MAX_PERIODS:
// a setup of the period rate, discount factor and coupon, a pass for each coupon period, a pass
// for the face value and then the final divisions. A zero price skips the durations and
// convexity, and a zero market price skips the yield division. The result is shown for exactly
// one cycle with result_valid_o high and cannot be stalled; a new start_i may be given in that
// same cycle.
module coupon_bond_price_duration_convexity_core
  import cbpdc_pkg::*;
#(
  parameter int MAX_PERIODS = MAX_PERIODS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  start_i,
  input  logic [MONEY_W-1:0]    market_price_i,
  output logic                  busy_o,
  output logic                  result_valid_o,
  output logic [MONEY_W-1:0]    bond_price_o,
  output logic [DUR_W-1:0]      macaulay_years_o,
  output logic [DUR_W-1:0]      modified_years_o,
  output logic [CONV_W-1:0]     convexity_value_o,
  output logic [YIELD_W-1:0]    cpn_yield_o,
  output logic                  price_zero_o,
  output logic                  market_zero_o
);

  localparam int IW = $clog2(MAX_PERIODS + 1);
  localparam int TW = 2 * IW + 1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_P, ST_V, ST_FC, ST_FLC, ST_CF, ST_D, ST_T, ST_W, ST_C,
    ST_PD, ST_MAC, ST_MD, ST_PD2, ST_CV, ST_CV1, ST_CV2, ST_CY, ST_FIN
  } state_e;

  state_e state_q;

  logic [MONEY_W-1:0] face_q;
  logic [RATE_W-1:0]  coupon_q, disc_q;
  logic [MAT_W-1:0]   mat_q;
  logic [FREQ_W-1:0]  freq_q;

  logic [MONEY_W-1:0] mkt_q;
  logic [FREQ_W-1:0]  f_q;
  logic [IW-1:0]      n_q, i_q;
  logic               face_step_q, issued_q, pz_q;
  logic [WORD_W-1:0]  p_q, v_q, cf_q, d_q, term_q, price_q, mac_q, mdur_q, conv_q, cy_q;
  logic [WIDE_W-1:0]  fvc_q, wsum_q, csum_q, den_q;

  logic              mul_start, div_start, is_mul, is_div;
  logic [WORD_W-1:0] mul_a, mul_b, mul_rnd;
  logic [WIDE_W-1:0] div_num, div_den, prod;
  logic              mul_done, div_done;
  logic [WORD_W-1:0] quo;
  logic [TW-1:0]     tt;
  logic [FREQ_W-1:0] f_in;
  logic [31:0]       n_full;
  logic [WIDE_W-1:0] annual_w;

  assign f_in   = (freq_q == '0) ? FREQ_W'(1) : freq_q;
  assign n_full = 32'(mat_q) * 32'(f_in);
  assign tt     = TW'(i_q) * TW'({1'b0, i_q} + (IW+1)'(1));
  assign mul_rnd = rnd32(prod);
  assign annual_w = ((fvc_q - prod) >> 24) + ((prod + WIDE_W'(24'h80_0000)) >> 24);

  always_comb begin
    is_mul  = 1'b0;
    is_div  = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    div_num = '0;
    div_den = '0;
    unique case (state_q)
      ST_P: begin
        is_div = 1'b1; div_num = WIDE_W'(disc_q); div_den = WIDE_W'(f_q);
      end
      ST_V: begin
        is_div  = 1'b1;
        div_num = WIDE_W'(1) << 56;
        div_den = (WIDE_W'(1) << 24) + WIDE_W'(p_q);
      end
      ST_FC: begin
        is_mul = 1'b1; mul_a = WORD_W'(face_q); mul_b = WORD_W'(coupon_q);
      end
      ST_FLC: begin
        is_mul = 1'b1; mul_a = WORD_W'(face_q[23:0]); mul_b = WORD_W'(coupon_q);
      end
      ST_CF: begin
        is_div = 1'b1; div_num = WIDE_W'(cf_q); div_den = WIDE_W'(f_q);
      end
      ST_D: begin
        is_mul = 1'b1; mul_a = d_q; mul_b = v_q;
      end
      ST_T: begin
        is_mul = 1'b1; mul_a = face_step_q ? WORD_W'(face_q) : cf_q; mul_b = d_q;
      end
      ST_W: begin
        is_mul = 1'b1; mul_a = WORD_W'(i_q); mul_b = term_q;
      end
      ST_C: begin
        is_mul = 1'b1; mul_a = WORD_W'(tt); mul_b = term_q;
      end
      ST_PD: begin
        is_mul = (price_q != '0); mul_a = price_q; mul_b = WORD_W'(f_q);
      end
      ST_MAC: begin
        is_div = 1'b1; div_num = wsum_q << 16; div_den = den_q;
      end
      ST_MD: begin
        is_mul = 1'b1; mul_a = mac_q; mul_b = v_q;
      end
      ST_PD2: begin
        is_mul = 1'b1; mul_a = price_q; mul_b = WORD_W'(8'(f_q) * 8'(f_q));
      end
      ST_CV: begin
        is_div = 1'b1; div_num = csum_q << 16; div_den = den_q;
      end
      ST_CV1, ST_CV2: begin
        is_mul = 1'b1; mul_a = conv_q; mul_b = v_q;
      end
      ST_CY: begin
        is_div = (mkt_q != '0); div_num = fvc_q; div_den = WIDE_W'(mkt_q);
      end
      default: begin
      end
    endcase
    mul_start = is_mul && !issued_q;
    div_start = is_div && !issued_q;
  end

  cbpdc_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .prod_o (prod)
  );

  cbpdc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (quo)
  );

  assign busy_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      issued_q       <= 1'b0;
      result_valid_o <= 1'b0;
      face_q         <= '0;
      coupon_q       <= '0;
      disc_q         <= '0;
      mat_q          <= '0;
      freq_q         <= FREQ_W'(1);
    end else begin
      result_valid_o <= (state_q == ST_FIN);
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_FACE:     face_q   <= cfg_data_i[MONEY_W-1:0];
          REG_COUPON:   coupon_q <= cfg_data_i[RATE_W-1:0];
          REG_DISCOUNT: disc_q   <= cfg_data_i[RATE_W-1:0];
          REG_MATURITY: mat_q    <= cfg_data_i[MAT_W-1:0];
          REG_FREQ:     freq_q   <= cfg_data_i[FREQ_W-1:0];
          default: begin
          end
        endcase
      end
      issued_q <= (issued_q || mul_start || div_start) && !(mul_done || div_done);
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            mkt_q       <= market_price_i;
            f_q         <= f_in;
            n_q         <= (n_full > 32'(MAX_PERIODS)) ? IW'(MAX_PERIODS) : IW'(n_full);
            face_step_q <= 1'b0;
            state_q     <= ST_P;
          end
        end
        ST_P: if (div_done) begin
          p_q <= quo; state_q <= ST_V;
        end
        ST_V: if (div_done) begin
          v_q <= quo; state_q <= ST_FC;
        end
        ST_FC: if (mul_done) begin
          fvc_q <= prod; state_q <= ST_FLC;
        end
        ST_FLC: if (mul_done) begin
          cf_q <= annual_w[WORD_W-1:0]; state_q <= ST_CF;
        end
        ST_CF: if (div_done) begin
          cf_q    <= quo;
          d_q     <= WORD_W'(1) << 32;
          price_q <= '0;
          wsum_q  <= '0;
          csum_q  <= '0;
          if (n_q == '0) begin
            i_q         <= '0;
            face_step_q <= 1'b1;
            state_q     <= ST_T;
          end else begin
            i_q     <= IW'(1);
            state_q <= ST_D;
          end
        end
        ST_D: if (mul_done) begin
          d_q <= mul_rnd; state_q <= ST_T;
        end
        ST_T: if (mul_done) begin
          term_q  <= mul_rnd;
          price_q <= price_q + mul_rnd;
          state_q <= ST_W;
        end
        ST_W: if (mul_done) begin
          wsum_q <= wsum_q + prod; state_q <= ST_C;
        end
        ST_C: if (mul_done) begin
          csum_q <= csum_q + prod;
          if (face_step_q) begin
            state_q <= ST_PD;
          end else if (i_q == n_q) begin
            face_step_q <= 1'b1;
            state_q     <= ST_T;
          end else begin
            i_q     <= i_q + IW'(1);
            state_q <= ST_D;
          end
        end
        ST_PD: begin
          pz_q <= (price_q == '0);
          if (price_q == '0) begin
            mac_q   <= '0;
            mdur_q  <= '0;
            conv_q  <= '0;
            state_q <= ST_CY;
          end else if (mul_done) begin
            den_q   <= prod;
            state_q <= ST_MAC;
          end
        end
        ST_MAC: if (div_done) begin
          mac_q <= quo; state_q <= ST_MD;
        end
        ST_MD: if (mul_done) begin
          mdur_q <= mul_rnd; state_q <= ST_PD2;
        end
        ST_PD2: if (mul_done) begin
          den_q <= prod; state_q <= ST_CV;
        end
        ST_CV: if (div_done) begin
          conv_q <= quo; state_q <= ST_CV1;
        end
        ST_CV1: if (mul_done) begin
          conv_q <= mul_rnd; state_q <= ST_CV2;
        end
        ST_CV2: if (mul_done) begin
          conv_q <= mul_rnd; state_q <= ST_CY;
        end
        ST_CY: begin
          if (mkt_q == '0) begin
            cy_q    <= '0;
            state_q <= ST_FIN;
          end else if (div_done) begin
            cy_q    <= quo;
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN) begin
      bond_price_o      <= (price_q[63:48] != '0) ? {MONEY_W{1'b1}} : price_q[47:0];
      macaulay_years_o  <= (mac_q[63:24] != '0) ? {DUR_W{1'b1}} : mac_q[23:0];
      modified_years_o  <= (mdur_q[63:24] != '0) ? {DUR_W{1'b1}} : mdur_q[23:0];
      convexity_value_o <= (conv_q[63:32] != '0) ? {CONV_W{1'b1}} : conv_q[31:0];
      cpn_yield_o       <= (cy_q[63:32] != '0) ? {YIELD_W{1'b1}} : cy_q[31:0];
      price_zero_o      <= pz_q;
      market_zero_o     <= (mkt_q == '0);
    end
  end

endmodule

// File: design/cbpdc_checker.sv
`timescale 1ns / 1ps
module cbpdc_checker
  import cbpdc_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               result_valid_o,
  input logic [DUR_W-1:0]   macaulay_years_o,
  input logic [DUR_W-1:0]   modified_years_o,
  input logic [CONV_W-1:0]  convexity_value_o,
  input logic [YIELD_W-1:0] cpn_yield_o,
  input logic               price_zero_o,
  input logic               market_zero_o
);

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("accepted transfer did not raise busy");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("result strobe longer than one cycle");

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o) else $error("result shown while busy");

  a_price_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && price_zero_o |-> macaulay_years_o == '0 && modified_years_o == '0
      && convexity_value_o == '0) else $error("zero price with nonzero durations");

  a_market_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && market_zero_o |-> cpn_yield_o == '0)
    else $error("zero market price with nonzero yield");

endmodule

bind coupon_bond_price_duration_convexity_core cbpdc_checker u_cbpdc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start_i          (start_i),
  .busy_o           (busy_o),
  .result_valid_o   (result_valid_o),
  .macaulay_years_o (macaulay_years_o),
  .modified_years_o (modified_years_o),
  .convexity_value_o(convexity_value_o),
  .cpn_yield_o      (cpn_yield_o),
  .price_zero_o     (price_zero_o),
  .market_zero_o    (market_zero_o)
);

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import cbpdc_pkg::*;

  localparam int LIMIT_CYCLES = 20000000;
  localparam logic [CFG_IDX_W-1:0] REG_IDX_TOP = 3'd7;

  typedef struct packed {
    logic [MONEY_W-1:0] bond_price;
    logic [DUR_W-1:0]   macaulay;
    logic [DUR_W-1:0]   modified;
    logic [CONV_W-1:0]  convexity;
    logic [YIELD_W-1:0] cur_yield;
    logic               price_zero;
    logic               market_zero;
  } bond_result_t;

  class bond_scoreboard;
    bond_result_t pending[$];
    int errors;

    function void mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
      errors++;
    endfunction

    function void note(bond_result_t e);
      pending.push_back(e);
    endfunction

    function void check(bond_result_t got);
      bond_result_t e;
      if (pending.size() == 0) begin
        mismatch("unexpected result", 64'(got.bond_price), 64'd0);
        return;
      end
      e = pending.pop_front();
      if (got.bond_price !== e.bond_price)
        mismatch("bond_price", 64'(got.bond_price), 64'(e.bond_price));
      if (got.macaulay !== e.macaulay)
        mismatch("macaulay_years", 64'(got.macaulay), 64'(e.macaulay));
      if (got.modified !== e.modified)
        mismatch("modified_years", 64'(got.modified), 64'(e.modified));
      if (got.convexity !== e.convexity)
        mismatch("convexity", 64'(got.convexity), 64'(e.convexity));
      if (got.cur_yield !== e.cur_yield)
        mismatch("cpn_yield", 64'(got.cur_yield), 64'(e.cur_yield));
      if (got.price_zero !== e.price_zero)
        mismatch("price_zero", 64'(got.price_zero), 64'(e.price_zero));
      if (got.market_zero !== e.market_zero)
        mismatch("market_zero", 64'(got.market_zero), 64'(e.market_zero));
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  start_i = 1'b0;
  logic [MONEY_W-1:0]    market_price_i = '0;
  logic                  busy_o;
  logic                  result_valid_o;
  logic [MONEY_W-1:0]    bond_price_o;
  logic [DUR_W-1:0]      macaulay_years_o;
  logic [DUR_W-1:0]      modified_years_o;
  logic [CONV_W-1:0]     convexity_value_o;
  logic [YIELD_W-1:0]    cpn_yield_o;
  logic                  price_zero_o;
  logic                  market_zero_o;

  coupon_bond_price_duration_convexity_core uut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  bond_scoreboard sb = new();
  int unsigned cycles = 0;

  logic [MONEY_W-1:0] face_q = '0;
  logic [RATE_W-1:0]  coupon_q = '0;
  logic [RATE_W-1:0]  disc_q = '0;
  logic [MAT_W-1:0]   mat_q = '0;
  logic [FREQ_W-1:0]  freq_q = FREQ_W'(1);

  function automatic logic [127:0] mul64(logic [63:0] a, logic [63:0] b);
    return {64'd0, a} * {64'd0, b};
  endfunction

  function automatic logic [63:0] round_q32(logic [127:0] x);
    logic [127:0] s;
    s = x + 128'h8000_0000;
    return (s[127:96] != 0) ? {64{1'b1}} : s[95:32];
  endfunction

  function automatic logic [63:0] div_round(logic [127:0] num, logic [127:0] den);
    logic [127:0] q;
    if (den == 0) return 64'd0;
    q = (num + (den >> 1)) / den;
    return (q[127:64] != 0) ? {64{1'b1}} : q[63:0];
  endfunction

  function automatic logic [63:0] clip(logic [63:0] x, logic [63:0] top);
    return (x > top) ? top : x;
  endfunction

  function automatic bond_result_t price_bond(logic [MONEY_W-1:0] mkt);
    logic [63:0] f, n, p, v, d, annual, cf, price, term, mac, mdur, conv, cy, i;
    logic [127:0] wsum, csum;
    bond_result_t r;
    f = (freq_q != 0) ? 64'(freq_q) : 64'd1;
    n = 64'(mat_q) * f;
    if (n > MAX_PERIODS_DEF) n = MAX_PERIODS_DEF;
    p = (64'(disc_q) + f / 2) / f;
    v = ((64'd1 << 56) + ((64'd1 << 24) + p) / 2) / ((64'd1 << 24) + p);
    annual = (64'(face_q) >> 24) * 64'(coupon_q)
           + (((64'(face_q) & 64'hFF_FFFF) * 64'(coupon_q) + 64'h80_0000) >> 24);
    cf = (annual + f / 2) / f;
    d = 64'd1 << 32;
    price = 0;
    wsum = 0;
    csum = 0;
    mac = 0;
    mdur = 0;
    conv = 0;
    cy = 0;
    for (i = 1; i <= n; i++) begin
      d = round_q32(mul64(d, v));
      term = round_q32(mul64(cf, d));
      price += term;
      wsum += mul64(i, term);
      csum += mul64(i * (i + 1), term);
    end
    term = round_q32(mul64(64'(face_q), d));
    price += term;
    wsum += mul64(n, term);
    csum += mul64(n * (n + 1), term);
    if (price != 0) begin
      mac = div_round(wsum << 16, mul64(price, f));
      mdur = round_q32(mul64(mac, v));
      conv = div_round(csum << 16, mul64(price, f * f));
      conv = round_q32(mul64(conv, v));
      conv = round_q32(mul64(conv, v));
    end
    if (mkt != 0) cy = div_round(mul64(64'(face_q), 64'(coupon_q)), {80'd0, mkt});
    r.bond_price = MONEY_W'(clip(price, 64'hFFFF_FFFF_FFFF));
    r.macaulay = DUR_W'(clip(mac, 64'hFF_FFFF));
    r.modified = DUR_W'(clip(mdur, 64'hFF_FFFF));
    r.convexity = CONV_W'(clip(conv, 64'hFFFF_FFFF));
    r.cur_yield = YIELD_W'(clip(cy, 64'hFFFF_FFFF));
    r.price_zero = (price == 0);
    r.market_zero = (mkt == 0);
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) sb.note(price_bond(market_price_i));
      if (result_valid_o)
        sb.check({bond_price_o, macaulay_years_o, modified_years_o, convexity_value_o,
                  cpn_yield_o, price_zero_o, market_zero_o});
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    case (idx)
      REG_FACE:     face_q = data[MONEY_W-1:0];
      REG_COUPON:   coupon_q = data[RATE_W-1:0];
      REG_DISCOUNT: disc_q = data[RATE_W-1:0];
      REG_MATURITY: mat_q = data[MAT_W-1:0];
      REG_FREQ:     freq_q = data[FREQ_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_terms(logic [47:0] fv, logic [47:0] cr, logic [47:0] dr,
                           logic [47:0] mat, logic [47:0] fq);
    cfg_write(REG_FACE, fv);
    cfg_write(REG_COUPON, cr);
    cfg_write(REG_DISCOUNT, dr);
    cfg_write(REG_MATURITY, mat);
    cfg_write(REG_FREQ, fq);
    if ($urandom_range(0, 3) == 0)
      cfg_write(CFG_IDX_W'($urandom_range(REG_FREQ + 1, REG_IDX_TOP)),
                CFG_DATA_W'({$urandom, $urandom}));
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic wait_idle();
    while (sb.pending.size() != 0 || busy_o) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic send_price(logic [MONEY_W-1:0] mkt, int unsigned gap);
    @(negedge clk_i);
    start_i = 1'b1;
    market_price_i = mkt;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
    start_i = 1'b0;
    market_price_i = MONEY_W'({$urandom, $urandom});
    repeat (gap) @(negedge clk_i);
  endtask

  function automatic logic [MONEY_W-1:0] rand_price();
    int unsigned k;
    k = $urandom_range(0, 19);
    if (k == 0) return '0;
    if (k == 1) return '1;
    if (k < 8) return MONEY_W'($urandom_range(1, 200)) << 16;
    return MONEY_W'({$urandom, $urandom});
  endfunction

  function automatic logic [RATE_W-1:0] rand_rate();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k == 0) return '0;
    if (k == 1) return '1;
    if (k < 6) return RATE_W'($urandom_range(0, 2500000));
    return RATE_W'($urandom);
  endfunction

  function automatic int unsigned rand_gap(bit busy_phase);
    int unsigned k;
    if (busy_phase) return 0;
    k = $urandom_range(0, 99);
    if (k < 70) return $urandom_range(0, 2);
    if (k < 95) return $urandom_range(3, 20);
    return $urandom_range(50, 300);
  endfunction

  initial begin
    bit no_gaps;
    int unsigned mat;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    send_price('0, 0);
    send_price('1, 0);
    wait_idle();
    set_terms(48'd100 << 16, 48'd838861, 48'd1006633, 48'd10, 48'd2);
    send_price(48'd98 << 16, 1);
    send_price(48'd1, 0);
    send_price('0, 3);
    wait_idle();
    set_terms(48'd100 << 16, 48'd838861, 48'd1006633, 48'd0, 48'd4);
    send_price(48'd100 << 16, 0);
    wait_idle();
    set_terms(48'd1000 << 16, 48'd500000, 48'd700000, 48'd3, 48'd0);
    send_price(48'd950 << 16, 0);
    wait_idle();
    set_terms('1, '1, '1, 48'd127, 48'd15);
    send_price('1, 0);
    send_price(48'd1, 0);
    wait_idle();
    set_terms('1, '1, '0, 48'd64, 48'd12);
    send_price(48'd1 << 16, 0);
    wait_idle();
    set_terms('0, '1, 48'd1006633, 48'd5, 48'd12);
    send_price(48'd5 << 16, 0);
    wait_idle();
    set_terms(48'd1, 48'd1, '1, 48'd2, 48'd1);
    send_price(48'd3, 0);
    wait_idle();
    set_terms(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
              48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
              48'({$urandom, $urandom}));
    send_price(rand_price(), 0);
    wait_idle();

    for (int ph = 0; ph < 24; ph++) begin
      mat = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
      set_terms(($urandom_range(0, 9) == 0) ? 48'(rand_price()) : MONEY_W'({$urandom, $urandom}),
                rand_rate(), rand_rate(), 48'(mat), 48'($urandom_range(0, 15)));
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 25; k++) send_price(rand_price(), rand_gap(no_gaps));
      wait_idle();
    end

    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
